// File: design/imu_esg_pkg.sv
`timescale 1ns / 1ps

package imu_esg_pkg;

    localparam int GYRO_BITS  = 16;
    localparam int TICK_W     = 32;
    localparam int SLEW_FRAC  = 24;
    localparam int BOUND_W    = 2 * TICK_W;
    localparam int BOUND_HI_W = BOUND_W - SLEW_FRAC;
    localparam int NUM_AXES   = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic [TICK_W-1:0] MIN_INTERVAL_RST    = 32'd20000;
    localparam logic [TICK_W-1:0] MAX_INTERVAL_RST    = 32'd20000000;
    localparam logic [TICK_W-1:0] NO_EDGE_TIMEOUT_RST = 32'd2000000;
    localparam logic [TICK_W-1:0] STUCK_TIMEOUT_RST   = 32'd20000000;
    localparam logic [TICK_W-1:0] SLEW_COEFF_RST      = 32'd33554;
    localparam logic [TICK_W-1:0] BASE_SEQUENCE_RST   = 32'd0;
    localparam logic [TICK_W-1:0] BASE_TIMESTAMP_RST  = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_INTERVAL    = 3'd0,
        REG_MAX_INTERVAL    = 3'd1,
        REG_NO_EDGE_TIMEOUT = 3'd2,
        REG_STUCK_TIMEOUT   = 3'd3,
        REG_SLEW_COEFF      = 3'd4,
        REG_BASE_SEQUENCE   = 3'd5,
        REG_BASE_TIMESTAMP  = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_OK    = 2'd2,
        CLS_LONG  = 2'd3
    } interval_class_t;

    typedef logic signed [GYRO_BITS-1:0] gyro_t;

    typedef struct packed {
        logic [TICK_W-1:0] edge_sequence;
        logic [TICK_W-1:0] edge_timestamp;
        logic [TICK_W-1:0] now_ticks;
        logic              sensor_present;
        gyro_t             gyro_x;
        gyro_t             gyro_y;
        gyro_t             gyro_z;
    } poll_t;

    typedef struct packed {
        logic              process;
        logic              duplicate;
        logic              timed_out;
        logic [TICK_W-1:0] interval_ticks;
        interval_class_t   interval_class;
        logic              accept;
        logic              slew_fail;
        logic              use_fault_interval;
        logic              verify_request;
        logic [TICK_W-1:0] missed_now;
        logic [TICK_W-1:0] missed_total;
        logic [TICK_W-1:0] stale_ticks;
    } verdict_t;

endpackage

// File: design/imu_esg_lane.sv
`timescale 1ns / 1ps

module imu_esg_lane
    import imu_esg_pkg::*;
(
    input  gyro_t                 sample,
    input  gyro_t                 reference,
    input  logic [BOUND_HI_W-1:0] bound_hi,
    output logic                  exceed
);

    logic signed [GYRO_BITS:0] diff;
    logic [GYRO_BITS:0]        mag;

    // mag * 2^24 > bound holds exactly when mag exceeds the integer part of bound / 2^24.
    always_comb
    begin
        diff   = {sample[GYRO_BITS-1], sample} - {reference[GYRO_BITS-1], reference};
        mag    = diff[GYRO_BITS] ? (GYRO_BITS+1)'(-diff) : (GYRO_BITS+1)'(diff);
        exceed = BOUND_HI_W'(mag) > bound_hi;
    end

endmodule

// File: design/imu_edge_sample_gate.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     in_data (poll_t)
// out       output     out_valid / out_stall   out_data (verdict_t)
// cfg       input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each request is decided in the cycle it is accepted; its registered verdict shows the cycle after.
// One request per cycle is sustained while out_stall is low; the state update (sequence, timestamp,
// slew reference, missed count) is registered with the verdict; one 32x32 multiplier forms the bound.
// Reset is asynchronous and active low; all but out_data_reg take documented reset values at once.
// A stalled verdict holds in the output register and input is stalled only while it waits.
module imu_edge_sample_gate
    import imu_esg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  poll_t                in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output verdict_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data
);

    logic [TICK_W-1:0] min_interval_reg;
    logic [TICK_W-1:0] max_interval_reg;
    logic [TICK_W-1:0] no_edge_timeout_reg;
    logic [TICK_W-1:0] stuck_timeout_reg;
    logic [TICK_W-1:0] slew_coeff_reg;

    logic [TICK_W-1:0] last_sequence_reg, last_sequence_next;
    logic [TICK_W-1:0] last_timestamp_reg, last_timestamp_next;
    logic [TICK_W-1:0] missed_count_reg, missed_count_next;
    gyro_t             accepted_gyro_reg [NUM_AXES];
    gyro_t             accepted_gyro_next [NUM_AXES];

    logic              out_valid_reg, out_valid_next;
    verdict_t          out_data_reg, out_data_next;

    logic              in_take;
    logic              cfg_take;
    gyro_t             sample [NUM_AXES];
    logic [NUM_AXES-1:0] exceed;
    logic [BOUND_W-1:0]  bound;

    logic              is_new;
    logic              timed_out;
    logic              process;
    logic              duplicate;
    logic              slew_run;
    logic              accept;
    logic [TICK_W-1:0] stale;
    logic [TICK_W-1:0] step;
    logic [TICK_W-1:0] missed_now;
    logic [TICK_W-1:0] interval;
    interval_class_t   cls;

    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sample[0] = in_data.gyro_x;
    assign sample[1] = in_data.gyro_y;
    assign sample[2] = in_data.gyro_z;

    always_comb
    begin
        stale     = in_data.now_ticks - in_data.edge_timestamp;
        is_new    = in_data.edge_sequence != last_sequence_reg;
        timed_out = stale > no_edge_timeout_reg;
        process   = is_new || timed_out;
        step      = in_data.edge_sequence - last_sequence_reg;
        missed_now = (step > TICK_W'(1)) ? step - TICK_W'(1) : '0;
        interval  = is_new ? in_data.edge_timestamp - last_timestamp_reg : '0;

        // The window tests run in the order ok, short, long so that an inverted window
        // still classifies the same way.
        if (!is_new)
            cls = CLS_NONE;
        else if (interval >= min_interval_reg && interval <= max_interval_reg)
            cls = CLS_OK;
        else if (interval != '0 && interval < min_interval_reg)
            cls = CLS_SHORT;
        else if (interval > max_interval_reg)
            cls = CLS_LONG;
        else
            cls = CLS_NONE;

        duplicate = is_new && (cls == CLS_SHORT);
        bound     = BOUND_W'(slew_coeff_reg) * BOUND_W'(interval);
        slew_run  = is_new && (cls == CLS_OK) && in_data.sensor_present;
    end

    assign accept = slew_run && (exceed == '0);

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_lane
        imu_esg_lane u_lane (
            .sample    (sample[a]),
            .reference (accepted_gyro_reg[a]),
            .bound_hi  (bound[BOUND_W-1:SLEW_FRAC]),
            .exceed    (exceed[a])
        );
    end

    // Merge of the lane results with the edge bookkeeping.
    always_comb
    begin
        out_data_next.process            = process;
        out_data_next.duplicate          = duplicate;
        out_data_next.timed_out          = timed_out;
        out_data_next.interval_ticks     = interval;
        out_data_next.interval_class     = cls;
        out_data_next.accept             = accept;
        out_data_next.slew_fail          = slew_run && (exceed != '0);
        out_data_next.use_fault_interval = process && !is_new;
        out_data_next.verify_request     = process && !is_new && (stale >= stuck_timeout_reg);
        out_data_next.missed_now         = missed_now;
        out_data_next.missed_total       = missed_count_reg + missed_now;
        out_data_next.stale_ticks        = stale;
    end

    always_comb
    begin
        last_sequence_next  = last_sequence_reg;
        last_timestamp_next = last_timestamp_reg;
        missed_count_next   = missed_count_reg;
        accepted_gyro_next  = accepted_gyro_reg;
        if (cfg_take && cfg_index == REG_BASE_SEQUENCE)
            last_sequence_next = cfg_data;
        if (cfg_take && cfg_index == REG_BASE_TIMESTAMP)
            last_timestamp_next = cfg_data;
        if (in_take && is_new)
        begin
            last_sequence_next = in_data.edge_sequence;
            missed_count_next  = missed_count_reg + missed_now;
            if (!duplicate)
                last_timestamp_next = in_data.edge_timestamp;
        end
        if (in_take && accept)
            accepted_gyro_next = sample;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg    <= MIN_INTERVAL_RST;
            max_interval_reg    <= MAX_INTERVAL_RST;
            no_edge_timeout_reg <= NO_EDGE_TIMEOUT_RST;
            stuck_timeout_reg   <= STUCK_TIMEOUT_RST;
            slew_coeff_reg      <= SLEW_COEFF_RST;
        end
        else if (cfg_take)
        begin
            case (cfg_index)
                REG_MIN_INTERVAL:    min_interval_reg    <= cfg_data;
                REG_MAX_INTERVAL:    max_interval_reg    <= cfg_data;
                REG_NO_EDGE_TIMEOUT: no_edge_timeout_reg <= cfg_data;
                REG_STUCK_TIMEOUT:   stuck_timeout_reg   <= cfg_data;
                REG_SLEW_COEFF:      slew_coeff_reg      <= cfg_data;
                // The baseline registers act only by seeding the stored edge.
                REG_BASE_SEQUENCE,
                REG_BASE_TIMESTAMP:  ;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sequence_reg  <= BASE_SEQUENCE_RST;
            last_timestamp_reg <= BASE_TIMESTAMP_RST;
            missed_count_reg   <= '0;
            for (int i = 0; i < NUM_AXES; i++)
                accepted_gyro_reg[i] <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            last_sequence_reg  <= last_sequence_next;
            last_timestamp_reg <= last_timestamp_next;
            missed_count_reg   <= missed_count_next;
            accepted_gyro_reg  <= accepted_gyro_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_accept_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.accept && out_data_reg.slew_fail))
        else $error("accept and slew_fail both set");

    a_dup_short: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.duplicate) |->
            (out_data_reg.process && out_data_reg.interval_class == CLS_SHORT))
        else $error("duplicate without a short interval");

    a_fault_no_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.use_fault_interval) |->
            (out_data_reg.interval_ticks == '0 && !out_data_reg.accept))
        else $error("fault interval with a new edge");

    a_ref_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && accept) |=>
            (accepted_gyro_reg[0] == $past(in_data.gyro_x) &&
             accepted_gyro_reg[2] == $past(in_data.gyro_z)))
        else $error("slew reference not updated on accept");

    a_seq_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && is_new) |=> (last_sequence_reg == $past(in_data.edge_sequence)))
        else $error("new edge sequence not consumed");
`endif

endmodule
